@@ hw/rtl/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// USB presence detector package
// Shared types, register indexes and reset values of the presence detector.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int TICK_W    = 32;
    localparam int TIMER_W   = 16;
    localparam int CODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURN_DURATION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_CODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USB_CODE       = 3'd5;

    localparam logic [TIMER_W-1:0] RST_ANSWER_TIMEOUT = 16'd200;
    localparam logic [TIMER_W-1:0] RST_QUIET_TIMEOUT  = 16'd50;
    localparam logic [TIMER_W-1:0] RST_BURN_DURATION  = 16'd30000;
    localparam logic [TIMER_W-1:0] RST_PROBE_INTERVAL = 16'd25;
    localparam logic [CODE_W-1:0]  RST_BASE_CODE      = 2'd1;
    localparam logic [CODE_W-1:0]  RST_USB_CODE       = 2'd2;

    localparam logic [CODE_W-1:0] LINES_BOTH_DOWN = 2'b11;

    typedef struct packed {
        logic [TIMER_W-1:0] answer_timeout;
        logic [TIMER_W-1:0] quiet_timeout;
        logic [TIMER_W-1:0] burn_duration;
        logic [TIMER_W-1:0] probe_interval;
        logic [CODE_W-1:0]  base_code;
        logic [CODE_W-1:0]  usb_code;
    } t_cfg;

    typedef struct packed {
        logic [TICK_W-1:0] now_ticks;
        logic              stack_running;
        logic              host_enumerated;
        logic              session_alive;
        logic [CODE_W-1:0] charge_source;
        logic [CODE_W-1:0] line_sample;
    } t_poll;

    typedef struct packed {
        logic plugged;
        logic connected_now;
        logic sample_taken;
    } t_result;

endpackage

@@ hw/rtl/upd_core.sv @@
// ----------------------------------------------------------------------------
// USB presence detector decision core
// Holds the detector state and computes one poll's decision and next state.
// ----------------------------------------------------------------------------
module upd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  upd_pkg::t_poll  i_poll,
    input  upd_pkg::t_cfg   i_cfg,
    output upd_pkg::t_result o_result
);
    import upd_pkg::*;

    logic              r_stack_seen, r_enum_seen, r_quiet_armed, r_burn_active;
    logic              r_last_decision, r_debounced;
    logic [TICK_W-1:0] r_start_time, r_quiet_start, r_burn_end, r_lines_time;
    logic [CODE_W-1:0] r_burn_source, r_lines_latched;

    logic              n_stack_seen, n_enum_seen, n_quiet_armed, n_burn_active;
    logic              n_last_decision, n_debounced;
    logic [TICK_W-1:0] n_start_time, n_quiet_start, n_burn_end, n_lines_time;
    logic [CODE_W-1:0] n_burn_source, n_lines_latched;

    logic              dec, sampled, blocked;
    logic              enum_eff, quiet_eff;
    logic [TICK_W-1:0] start_eff, lines_time_eff, burn_diff;
    logic [CODE_W-1:0] lines_eff;
    logic [TICK_W-1:0] answer_ext, quiet_ext, burn_ext, probe_ext;

    assign answer_ext = {{(TICK_W-TIMER_W){1'b0}}, i_cfg.answer_timeout};
    assign quiet_ext  = {{(TICK_W-TIMER_W){1'b0}}, i_cfg.quiet_timeout};
    assign burn_ext   = {{(TICK_W-TIMER_W){1'b0}}, i_cfg.burn_duration};
    assign probe_ext  = {{(TICK_W-TIMER_W){1'b0}}, i_cfg.probe_interval};

    always_comb begin
        n_stack_seen    = r_stack_seen;
        n_enum_seen     = r_enum_seen;
        n_quiet_armed   = r_quiet_armed;
        n_burn_active   = r_burn_active;
        n_start_time    = r_start_time;
        n_quiet_start   = r_quiet_start;
        n_burn_end      = r_burn_end;
        n_lines_time    = r_lines_time;
        n_burn_source   = r_burn_source;
        n_lines_latched = r_lines_latched;
        dec             = 1'b0;
        sampled         = 1'b0;
        blocked         = 1'b0;

        start_eff      = r_stack_seen ? r_start_time : i_poll.now_ticks;
        enum_eff       = (r_stack_seen & r_enum_seen) | i_poll.host_enumerated;
        quiet_eff      = r_stack_seen & r_quiet_armed;
        lines_time_eff = r_stack_seen ? (i_poll.now_ticks - probe_ext) : r_lines_time;
        lines_eff      = r_stack_seen ? '0 : r_lines_latched;
        burn_diff      = i_poll.now_ticks - r_burn_end;

        if (i_poll.stack_running) begin
            n_stack_seen  = 1'b1;
            n_start_time  = start_eff;
            n_enum_seen   = enum_eff;
            n_quiet_armed = quiet_eff;
            if (!enum_eff) begin
                if ((i_poll.now_ticks - start_eff) < answer_ext) begin
                    dec = 1'b1;
                end else begin
                    n_burn_end    = i_poll.now_ticks + burn_ext;
                    n_burn_active = 1'b1;
                    n_burn_source = i_poll.charge_source;
                end
            end else if (i_poll.session_alive) begin
                n_quiet_armed = 1'b0;
                dec           = 1'b1;
            end else if (!quiet_eff) begin
                n_quiet_armed = 1'b1;
                n_quiet_start = i_poll.now_ticks;
                dec           = 1'b1;
            end else begin
                dec = (i_poll.now_ticks - r_quiet_start) < quiet_ext;
            end
        end else begin
            n_stack_seen    = 1'b0;
            n_quiet_armed   = 1'b0;
            n_lines_time    = lines_time_eff;
            n_lines_latched = lines_eff;
            if (i_poll.charge_source != i_cfg.base_code) begin
                if (r_burn_active) begin
                    if (i_poll.charge_source != r_burn_source || !burn_diff[TICK_W-1]) begin
                        n_burn_active = 1'b0;
                    end else begin
                        blocked = 1'b1;
                    end
                end
                if (blocked) begin
                    dec = 1'b0;
                end else if (i_poll.charge_source == i_cfg.usb_code) begin
                    dec = 1'b1;
                end else begin
                    if ((i_poll.now_ticks - lines_time_eff) >= probe_ext) begin
                        n_lines_latched = i_poll.line_sample;
                        n_lines_time    = i_poll.now_ticks;
                        sampled         = 1'b1;
                    end
                    dec = (n_lines_latched == LINES_BOTH_DOWN);
                end
            end
        end

        if (dec == r_last_decision) begin
            n_debounced     = dec;
            n_last_decision = r_last_decision;
        end else begin
            n_debounced     = r_debounced;
            n_last_decision = dec;
        end
    end

    assign o_result.plugged       = n_debounced;
    assign o_result.connected_now = dec;
    assign o_result.sample_taken  = sampled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_seen    <= 1'b0;
            r_enum_seen     <= 1'b0;
            r_quiet_armed   <= 1'b0;
            r_burn_active   <= 1'b0;
            r_last_decision <= 1'b0;
            r_debounced     <= 1'b0;
            r_start_time    <= '0;
            r_quiet_start   <= '0;
            r_burn_end      <= '0;
            r_lines_time    <= '0;
            r_burn_source   <= '0;
            r_lines_latched <= '0;
        end else if (i_take) begin
            r_stack_seen    <= n_stack_seen;
            r_enum_seen     <= n_enum_seen;
            r_quiet_armed   <= n_quiet_armed;
            r_burn_active   <= n_burn_active;
            r_last_decision <= n_last_decision;
            r_debounced     <= n_debounced;
            r_start_time    <= n_start_time;
            r_quiet_start   <= n_quiet_start;
            r_burn_end      <= n_burn_end;
            r_lines_time    <= n_lines_time;
            r_burn_source   <= n_burn_source;
            r_lines_latched <= n_lines_latched;
        end
    end

endmodule

@@ hw/rtl/usb_presence_detector_unit.sv @@
// ----------------------------------------------------------------------------
// USB presence detector
// Streaming top level: configuration registers, poll request and result
// register around the decision core.
// ----------------------------------------------------------------------------
// One poll request is taken per clock cycle and its result appears in the
// output register on the next cycle; a request is taken while a result waits
// as long as the downstream side takes that result in the same cycle. The
// figure is set by the state update in the decision core, which
// works on the request as it is accepted.
module usb_presence_detector_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [upd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [upd_pkg::CFG_DAT_W-1:0]   i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // now_ticks[31:0], stack_running[32], host_enumerated[33],
    // session_alive[34], charge_source[36:35], line_sample[38:37], zero[39]
    input  logic [upd_pkg::S_DATA_W-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // plugged[0], connected_now[1], sample_taken[2], zero[7:3]
    output logic [upd_pkg::M_DATA_W-1:0]    m_axis_tdata
);
    import upd_pkg::*;

    t_cfg    r_cfg;
    t_poll   poll;
    t_result result;
    t_result r_result;
    logic    r_out_valid;
    logic    take;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    assign poll.now_ticks       = s_axis_tdata[31:0];
    assign poll.stack_running   = s_axis_tdata[32];
    assign poll.host_enumerated = s_axis_tdata[33];
    assign poll.session_alive   = s_axis_tdata[34];
    assign poll.charge_source   = s_axis_tdata[36:35];
    assign poll.line_sample     = s_axis_tdata[38:37];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.answer_timeout <= RST_ANSWER_TIMEOUT;
            r_cfg.quiet_timeout  <= RST_QUIET_TIMEOUT;
            r_cfg.burn_duration  <= RST_BURN_DURATION;
            r_cfg.probe_interval <= RST_PROBE_INTERVAL;
            r_cfg.base_code      <= RST_BASE_CODE;
            r_cfg.usb_code       <= RST_USB_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ANSWER_TIMEOUT: r_cfg.answer_timeout <= i_cfg_wdata;
                CFG_QUIET_TIMEOUT:  r_cfg.quiet_timeout  <= i_cfg_wdata;
                CFG_BURN_DURATION:  r_cfg.burn_duration  <= i_cfg_wdata;
                CFG_PROBE_INTERVAL: r_cfg.probe_interval <= i_cfg_wdata;
                CFG_BASE_CODE:      r_cfg.base_code      <= i_cfg_wdata[CODE_W-1:0];
                CFG_USB_CODE:       r_cfg.usb_code       <= i_cfg_wdata[CODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    upd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_poll   (poll),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W-3){1'b0}}, r_result.sample_taken,
                            r_result.connected_now, r_result.plugged};

endmodule
